### hdl/direct_mapped_writeback_cache_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DMWC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmwc check failed");

// Next-cycle implication, disabled while reset is high.
`define DMWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmwc check failed");

`endif

### hdl/dmwc_pkg.sv
`default_nettype none
package dmwc_pkg;

  localparam int ADDR_W       = 16;
  localparam int OFFSET_W     = 4;
  localparam int LINE_W       = 4;
  localparam int TAG_W        = ADDR_W - OFFSET_W - LINE_W;
  localparam int ROW_ADDR_W   = ADDR_W - OFFSET_W;
  localparam int BLOCK_BYTES  = 1 << OFFSET_W;
  localparam int LINE_COUNT   = 1 << LINE_W;
  localparam int MEM_ROWS     = 1 << ROW_ADDR_W;
  localparam int ROW_W        = BLOCK_BYTES * 8;
  localparam int ACCESS_BYTES = 4;
  localparam int DATA_W       = ACCESS_BYTES * 8;
  localparam int INSIDE_W     = 3;
  localparam int MODE_W       = 2;

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_PEEK  = 2'd3
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic write_back;
    logic finish;
    logic use_cache;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cached;
    logic is_hit;
    logic victim_dirty;
    logic clear_last;
  } status_t;

  // Gather the bytes from the offset on; bytes past the block end read as zero.
  function automatic logic [DATA_W-1:0] row_extract(row_t row, logic [OFFSET_W-1:0] off);
    logic [DATA_W-1:0]   r;
    logic [OFFSET_W:0]   pos;
    r = '0;
    for (int k = 0; k < ACCESS_BYTES; k++) begin
      pos = {1'b0, off} + (OFFSET_W+1)'(k);
      if (pos < (OFFSET_W+1)'(BLOCK_BYTES)) begin
        r[DATA_W-1-8*k -: 8] = row[8*pos[OFFSET_W-1:0] +: 8];
      end
    end
    return r;
  endfunction

  // Store the word into the row from the offset on, dropping bytes past the block end.
  function automatic row_t row_merge(row_t row, logic [OFFSET_W-1:0] off,
                                     logic [DATA_W-1:0] wdata);
    row_t              r;
    logic [OFFSET_W:0] pos;
    r = row;
    for (int k = 0; k < ACCESS_BYTES; k++) begin
      pos = {1'b0, off} + (OFFSET_W+1)'(k);
      if (pos < (OFFSET_W+1)'(BLOCK_BYTES)) begin
        r[8*pos[OFFSET_W-1:0] +: 8] = wdata[DATA_W-1-8*k -: 8];
      end
    end
    return r;
  endfunction

  // Number of the four bytes that fall inside the block.
  function automatic logic [INSIDE_W-1:0] bytes_in_block(logic [OFFSET_W-1:0] off);
    logic [OFFSET_W:0] room;
    room = (OFFSET_W+1)'(BLOCK_BYTES) - {1'b0, off};
    if (room > (OFFSET_W+1)'(ACCESS_BYTES)) begin
      return INSIDE_W'(ACCESS_BYTES);
    end
    return room[INSIDE_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/direct_mapped_writeback_cache.sv
// Direct-mapped, write-back, write-allocate cache of 16 lines of 16 bytes in front of a
// 64 KiB byte memory. Raise start with mode, address and write_data while busy is low;
// the word is taken at that clock edge. Exactly one result follows, shown for a single
// cycle with done high, and it must be taken in that cycle because the block cannot
// hold it. After reset the block keeps busy high while it zeroes all 4096 rows of the
// backing memory, one 16-byte row per cycle. Memory load, memory peek, cache hits and
// clean misses pass through a lookup state and a finishing state, after which done is
// registered; a dirty miss adds a write-back state before the refill. The block takes
// no new word while one is in flight, but a new word may be started in the cycle that
// shows done. These steps follow from the registered reads of the backing memory and
// the cache data memory, and on a dirty miss from the extra write of the victim block.

`default_nettype none
module direct_mapped_writeback_cache (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dmwc_pkg::MODE_W-1:0]    mode,
  input  wire logic [dmwc_pkg::ADDR_W-1:0]    address,
  input  wire logic [dmwc_pkg::DATA_W-1:0]    write_data,
  output logic                                done,
  output logic                                hit,
  output logic [dmwc_pkg::LINE_W-1:0]         line_index,
  output logic [dmwc_pkg::DATA_W-1:0]         read_data,
  output logic [dmwc_pkg::INSIDE_W-1:0]       bytes_inside
);
  import dmwc_pkg::*;

  // The controller sequences each word; the datapath holds every store.
  cmd_t    cmd;
  status_t status;

  dmwc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Results are registered in the datapath on the final step of a word and
  // line up with the done strobe from the controller.
  dmwc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .hit          (hit),
    .line_index   (line_index),
    .read_data    (read_data),
    .bytes_inside (bytes_inside)
  );

endmodule
`default_nettype wire

### hdl/dmwc_ctrl.sv
`default_nettype none
module dmwc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  dmwc_pkg::status_t      status,
  output dmwc_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   done
);
  import dmwc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MEM_FIN,
    ST_HIT_FIN,
    ST_WRITE_BACK,
    ST_REFILL
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == ST_IDLE) && start;
    cmd.clear      = (state == ST_CLEAR);
    cmd.write_back = (state == ST_WRITE_BACK);
    cmd.finish     = (state == ST_MEM_FIN) || (state == ST_HIT_FIN) || (state == ST_REFILL);
    cmd.use_cache  = (state == ST_HIT_FIN);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status.cached) state_next = ST_MEM_FIN;
        else if (status.is_hit) state_next = ST_HIT_FIN;
        else if (status.victim_dirty) state_next = ST_WRITE_BACK;
        else state_next = ST_REFILL;
      end
      ST_WRITE_BACK: state_next = ST_REFILL;
      ST_MEM_FIN, ST_HIT_FIN, ST_REFILL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

endmodule
`default_nettype wire

### hdl/dmwc_datapath.sv
`default_nettype none
module dmwc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  dmwc_pkg::cmd_t                      cmd,
  output dmwc_pkg::status_t                   status,
  input  wire logic [dmwc_pkg::MODE_W-1:0]    mode,
  input  wire logic [dmwc_pkg::ADDR_W-1:0]    address,
  input  wire logic [dmwc_pkg::DATA_W-1:0]    write_data,
  output logic                                hit,
  output logic [dmwc_pkg::LINE_W-1:0]         line_index,
  output logic [dmwc_pkg::DATA_W-1:0]         read_data,
  output logic [dmwc_pkg::INSIDE_W-1:0]       bytes_inside
);
  import dmwc_pkg::*;

  // Captured word.
  mode_t               mode_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [DATA_W-1:0]   wdata_q;

  // Line state.
  logic [TAG_W-1:0]    tag_arr [LINE_COUNT];
  logic [LINE_COUNT-1:0] valid_arr;
  logic [LINE_COUNT-1:0] dirty_arr;

  // Memories: backing store and cache data, one block per row.
  row_t                mem_ram   [MEM_ROWS];
  row_t                cache_ram [LINE_COUNT];
  row_t                mem_q;
  row_t                cache_q;

  logic [ROW_ADDR_W-1:0] clr_cnt;

  logic [OFFSET_W-1:0] off;
  logic [LINE_W-1:0]   line;
  logic [TAG_W-1:0]    tag;
  logic [ROW_ADDR_W-1:0] row_addr;
  logic                cached;
  logic                stores;
  row_t                base_row;
  row_t                final_row;

  logic                  mem_we;
  logic [ROW_ADDR_W-1:0] mem_wa;
  row_t                  mem_wd;
  logic                  cache_we;
  logic                  refill;

  assign off      = addr_q[OFFSET_W-1:0];
  assign line     = addr_q[OFFSET_W +: LINE_W];
  assign tag      = addr_q[ADDR_W-1 -: TAG_W];
  assign row_addr = addr_q[ADDR_W-1:OFFSET_W];
  assign cached   = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
  assign stores   = (mode_q == MODE_WRITE) || (mode_q == MODE_LOAD);

  assign base_row  = cmd.use_cache ? cache_q : mem_q;
  assign final_row = stores ? row_merge(base_row, off, wdata_q) : base_row;

  assign refill   = cmd.finish && cached && !cmd.use_cache;
  assign cache_we = cmd.finish && cached && (!cmd.use_cache || (mode_q == MODE_WRITE));

  always_comb begin
    status              = '0;
    status.cached       = cached;
    status.is_hit       = valid_arr[line] && (tag_arr[line] == tag);
    status.victim_dirty = valid_arr[line] && dirty_arr[line];
    status.clear_last   = &clr_cnt;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = row_addr;
    mem_wd = final_row;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = '0;
    end else if (cmd.write_back) begin
      mem_we = 1'b1;
      mem_wa = {tag_arr[line], line};
      mem_wd = cache_q;
    end else if (cmd.finish && (mode_q == MODE_LOAD)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_ram[mem_wa] <= mem_wd;
    end
    mem_q <= mem_ram[row_addr];
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_ram[line] <= final_row;
    end
    cache_q <= cache_ram[line];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      valid_arr <= '0;
      dirty_arr <= '0;
      for (int i = 0; i < LINE_COUNT; i++) begin
        tag_arr[i] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (refill) begin
        tag_arr[line]   <= tag;
        valid_arr[line] <= 1'b1;
        dirty_arr[line] <= (mode_q == MODE_WRITE);
      end else if (cmd.finish && cmd.use_cache && (mode_q == MODE_WRITE)) begin
        dirty_arr[line] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= mode_t'(mode);
      addr_q  <= address;
      wdata_q <= write_data;
    end
    if (cmd.finish) begin
      hit          <= cmd.use_cache;
      line_index   <= line;
      read_data    <= row_extract(final_row, off);
      bytes_inside <= bytes_in_block(off);
    end
  end

endmodule
`default_nettype wire

### hdl/dmwc_checker.sv
`default_nettype none
`include "direct_mapped_writeback_cache_assert.svh"
module dmwc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic [dmwc_pkg::DATA_W-1:0]    read_data,
  input wire logic [dmwc_pkg::INSIDE_W-1:0]  bytes_inside
);
  import dmwc_pkg::*;

  // An accepted word keeps the block busy in the following cycle.
  `DMWC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // A result is shown only once the block is ready again.
  `DMWC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  // Each word gives a single one-cycle strobe.
  `DMWC_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // Byte count always lies between one and four.
  `DMWC_ASSERT_NOW(a_inside_range, clk, rst, done, (bytes_inside != 3'd0) && (bytes_inside <= 3'd4))
  // With only one byte inside the block the rest of the word reads as zero.
  `DMWC_ASSERT_NOW(a_tail_zero, clk, rst, done && (bytes_inside == 3'd1), read_data[23:0] == 24'd0)

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_checker (.*);
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the direct-mapped write-back cache. A scoreboard class
// keeps its own copy of the tags, the valid and dirty bits, the line bytes and the
// whole backing memory. It works out the expected result of every word that the
// block takes, and it compares each strobed result with the oldest expected one.
module testbench;
  import dmwc_pkg::*;

  localparam int MEM_BYTES   = MEM_ROWS * BLOCK_BYTES;
  // The post-reset memory clear keeps busy high while it zeroes all 4096 rows, so the
  // stall limit must sit well above that. Between later words there are only the steps
  // of one word and a random sender gap.
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_RANDOM  = 1430;
  // The last words of the run get no sender gaps, though one drain still falls among them.
  localparam int CALM_TAIL   = 300;
  localparam int SHOW_LIMIT  = 10;

  // One result of the block, as the scoreboard expects it.
  typedef struct packed {
    logic                hit;
    logic [LINE_W-1:0]   line;
    logic [DATA_W-1:0]   data;
    logic [INSIDE_W-1:0] in_block;
  } cache_result_t;

  class cache_scoreboard;
    logic [7:0]       mem_bytes [MEM_BYTES];
    logic [7:0]       line_bytes [LINE_COUNT][BLOCK_BYTES];
    logic [TAG_W-1:0] line_tag [LINE_COUNT];
    logic             line_valid [LINE_COUNT];
    logic             line_dirty [LINE_COUNT];
    cache_result_t    result_q[$];
    int               errors;

    // Everything is clear after reset, like the block itself.
    function void clear_state();
      foreach (mem_bytes[i]) mem_bytes[i] = '0;
      foreach (line_bytes[i, j]) line_bytes[i][j] = '0;
      foreach (line_tag[i]) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      result_q.delete();
      errors = 0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Apply one accepted word to the copy of the cache and memory, and queue the
    // result that the block has to show for it.
    function void note_word(mode_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
      logic [OFFSET_W-1:0] off;
      logic [LINE_W-1:0]   line;
      logic [TAG_W-1:0]    tag;
      logic [ADDR_W-1:0]   where;
      int                  count;
      cache_result_t       r;
      off   = addr[OFFSET_W-1:0];
      line  = addr[OFFSET_W +: LINE_W];
      tag   = addr[ADDR_W-1 -: TAG_W];
      count = BLOCK_BYTES - int'(off);
      if (count > ACCESS_BYTES) count = ACCESS_BYTES;
      r          = '0;
      r.line     = line;
      r.in_block = INSIDE_W'(count);
      if (op == MODE_LOAD || op == MODE_PEEK) begin
        // Straight to memory; a cached copy is neither updated nor consulted.
        for (int i = 0; i < count; i++) begin
          where = addr + ADDR_W'(i);
          if (op == MODE_LOAD) mem_bytes[where] = wdata[DATA_W-1-8*i -: 8];
          r.data[DATA_W-1-8*i -: 8] = mem_bytes[where];
        end
      end else begin
        if (line_valid[line] && line_tag[line] == tag) begin
          r.hit = 1'b1;
        end else begin
          if (line_valid[line] && line_dirty[line]) begin
            for (int i = 0; i < BLOCK_BYTES; i++)
              mem_bytes[{line_tag[line], line, OFFSET_W'(i)}] = line_bytes[line][i];
          end
          for (int i = 0; i < BLOCK_BYTES; i++)
            line_bytes[line][i] = mem_bytes[{tag, line, OFFSET_W'(i)}];
          line_tag[line]   = tag;
          line_valid[line] = 1'b1;
          line_dirty[line] = 1'b0;
        end
        if (op == MODE_WRITE) begin
          for (int i = 0; i < count; i++)
            line_bytes[line][int'(off) + i] = wdata[DATA_W-1-8*i -: 8];
          line_dirty[line] = 1'b1;
        end
        for (int i = 0; i < count; i++)
          r.data[DATA_W-1-8*i -: 8] = line_bytes[line][int'(off) + i];
      end
      result_q = {result_q, r};
    endfunction

    function void check_result(logic hit, logic [LINE_W-1:0] line,
                               logic [DATA_W-1:0] data, logic [INSIDE_W-1:0] in_block);
      cache_result_t want;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: result with nothing expected: hit=%0b line=%0d data=%08h inside=%0d",
                   $realtime, hit, line, data, in_block);
        return;
      end
      want = result_q.pop_front();
      if (hit !== want.hit || line !== want.line || data !== want.data ||
          in_block !== want.in_block) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: mismatch: expected hit=%0b line=%0d data=%08h inside=%0d, %s",
                   $realtime, want.hit, want.line, want.data, want.in_block,
                   $sformatf("got hit=%0b line=%0d data=%08h inside=%0d",
                             hit, line, data, in_block));
      end
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                start      = 1'b0;
  logic [MODE_W-1:0]   mode       = MODE_READ;
  logic [ADDR_W-1:0]   address    = '0;
  logic [DATA_W-1:0]   write_data = '0;
  logic                busy;
  logic                done;
  logic                hit;
  logic [LINE_W-1:0]   line_index;
  logic [DATA_W-1:0]   read_data;
  logic [INSIDE_W-1:0] bytes_inside;

  cache_scoreboard sb = new;

  direct_mapped_writeback_cache u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .done         (done),
    .hit          (hit),
    .line_index   (line_index),
    .read_data    (read_data),
    .bytes_inside (bytes_inside)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it. Every call is made right
  // after a rising edge, so busy still shows its value from before that edge.
  task automatic send_word(mode_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
    start      <= 1'b1;
    mode       <= op;
    address    <= addr;
    write_data <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(op, addr, wdata);
  endtask

  task automatic sender_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every result that is owed has been shown.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Results cannot be held off, so every strobed cycle is checked at its closing edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(hit, line_index, read_data, bytes_inside);
  end

  // Watchdog: the run is stuck if for too long no word is taken and no result shows.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stalled = 0;
      else stalled++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [TAG_W-1:0]  hot_tags [4];
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    mode_t             op;
    int                pick;
    sb.clear_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words. The first read misses on a block that was never loaded, so it
    // refills as zeros. Offsets 13 to 15 cut the word at the block end.
    send_word(MODE_READ,  16'h0000, 32'h1234_5678);
    send_word(MODE_LOAD,  16'h1230, 32'hFFFF_FFFF);
    send_word(MODE_LOAD,  16'hFFFF, 32'hA5A5_A5A5);
    send_word(MODE_PEEK,  16'hFFFC, 32'h0000_0000);
    send_word(MODE_READ,  16'h1230, 32'h0000_0000);  // clean miss, refill
    send_word(MODE_READ,  16'h1230, 32'h0000_0000);  // hit
    send_word(MODE_WRITE, 16'h1232, 32'h0000_0000);  // hit, marks the line dirty
    // A peek does not see the dirty bytes, and a load leaves the cached copy stale.
    send_word(MODE_PEEK,  16'h1230, 32'hFFFF_FFFF);
    send_word(MODE_LOAD,  16'h1234, 32'h1122_3344);
    send_word(MODE_READ,  16'h1234, 32'h0000_0000);
    // Same line, other tag: the dirty victim goes back to memory over the load.
    send_word(MODE_READ,  16'h4530, 32'h0000_0000);
    send_word(MODE_PEEK,  16'h1230, 32'h0000_0000);
    send_word(MODE_PEEK,  16'h1234, 32'h0000_0000);
    send_word(MODE_WRITE, 16'hFFFD, 32'hDEAD_BEEF);
    send_word(MODE_READ,  16'hFFFE, 32'h0000_0000);
    send_word(MODE_READ,  16'h00F0, 32'h0000_0000);
    send_word(MODE_PEEK,  16'hFFFC, 32'h0000_0000);
    send_word(MODE_WRITE, 16'h0000, 32'h0000_0000);
    send_word(MODE_READ,  16'hFF0F, 32'hFFFF_FFFF);
    send_word(MODE_PEEK,  16'h0000, 32'h0000_0000);
    send_word(MODE_LOAD,  16'h8000, 32'h8000_0001);
    send_word(MODE_READ,  16'h8000, 32'h0000_0000);
    drain_results();

    // Random words. Most addresses use a few hot tags so that hits, conflicts and
    // dirty write-backs are frequent; the rest range over the whole address space.
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    hot_tags[2] = TAG_W'($urandom);
    hot_tags[3] = TAG_W'($urandom);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 200 == 199) hot_tags[$urandom_range(0, 3)] = TAG_W'($urandom);
      if (n % 400 == 399) drain_results();
      if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
        sender_gap($urandom_range(1, 7));

      pick = $urandom_range(0, 99);
      if (pick < 15)      op = MODE_LOAD;
      else if (pick < 50) op = MODE_READ;
      else if (pick < 85) op = MODE_WRITE;
      else                op = MODE_PEEK;

      if ($urandom_range(0, 9) < 7) addr[ADDR_W-1 -: TAG_W] = hot_tags[$urandom_range(0, 3)];
      else                          addr[ADDR_W-1 -: TAG_W] = TAG_W'($urandom);
      addr[OFFSET_W +: LINE_W] = LINE_W'($urandom_range(0, LINE_COUNT - 1));
      if ($urandom_range(0, 3) == 0)
        addr[OFFSET_W-1:0] = OFFSET_W'($urandom_range(BLOCK_BYTES - ACCESS_BYTES,
                                                      BLOCK_BYTES - 1));
      else
        addr[OFFSET_W-1:0] = OFFSET_W'($urandom_range(0, BLOCK_BYTES - 1));

      pick = $urandom_range(0, 19);
      if (pick == 0)      wdata = '0;
      else if (pick == 1) wdata = '1;
      else                wdata = $urandom;

      send_word(op, addr, wdata);
    end

    drain_results();
    // Let any stray strobe show up before the verdict.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/dmwc_pkg.sv
hdl/dmwc_ctrl.sv
hdl/dmwc_datapath.sv
hdl/direct_mapped_writeback_cache.sv
hdl/dmwc_checker.sv
bench/testbench.sv
